// ===== src/bfra_pkg.sv =====
// types, constants and codes shared by the best-fit range allocator
// no dependencies

package bfra_pkg;

  localparam int PoolSize = 65536;
  localparam int MaxRuns  = 32;

  localparam int IdxW   = $clog2(MaxRuns);
  localparam int CntW   = $clog2(MaxRuns + 1);
  localparam int SlotW  = 16;
  localparam int LenW   = 17;

  localparam logic OpAlloc = 1'b0;
  localparam logic OpFree  = 1'b1;

  localparam logic [1:0] StOkRun     = 2'd0;
  localparam logic [1:0] StOkTop     = 2'd1;
  localparam logic [1:0] StNoSpace   = 2'd2;
  localparam logic [1:0] StTableFull = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic             opcode;
    logic [SlotW-1:0] start_index;
    logic [SlotW-1:0] run_length;
  } in_t;

  typedef struct packed {
    logic [SlotW-1:0] slot_index;
    logic [1:0]       status;
  } out_t;

  // write request into the run table
  typedef struct packed {
    logic             en;
    logic             start_en;
    logic [IdxW-1:0]  addr;
    logic [SlotW-1:0] start;
    logic [LenW-1:0]  len;
  } wr_t;

endpackage

// ===== src/bfra_run_table.sv =====
// run table: start and length of each free run, one write and one registered read
// depends on bfra_pkg

module bfra_run_table (
  input  logic                           clk_i,
  input  bfra_pkg::wr_t                  wr_i,
  input  logic [bfra_pkg::IdxW-1:0]      rd_addr_i,
  output logic [bfra_pkg::SlotW-1:0]     rd_start_o,
  output logic [bfra_pkg::LenW-1:0]      rd_len_o
);

  logic [bfra_pkg::SlotW-1:0] start_mem [bfra_pkg::MaxRuns];
  logic [bfra_pkg::LenW-1:0]  len_mem   [bfra_pkg::MaxRuns];

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      len_mem[wr_i.addr] <= wr_i.len;
      if (wr_i.start_en) begin
        start_mem[wr_i.addr] <= wr_i.start;
      end
    end
    rd_start_o <= start_mem[rd_addr_i];
    rd_len_o   <= len_mem[rd_addr_i];
  end

endmodule

// ===== src/best_fit_range_allocator.sv =====
// best-fit range allocator: sequencer that scans the run table one entry a cycle
// depends on bfra_pkg and bfra_run_table
// requests rejected or ignored up front skip the table scan and go straight to done
// a new request is taken only once the previous result has been registered out;
// the scan is serial, set by the single table read port
// reset: all runs invalid, top pointer zero, no result pending; table contents stay

module best_fit_range_allocator (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  bfra_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output bfra_pkg::out_t  out_data_o
);

  localparam int IdxW  = bfra_pkg::IdxW;
  localparam int CntW  = bfra_pkg::CntW;
  localparam int SlotW = bfra_pkg::SlotW;
  localparam int LenW  = bfra_pkg::LenW;
  localparam int NRuns = bfra_pkg::MaxRuns;

  localparam logic [LenW-1:0] PoolLimit = LenW'(bfra_pkg::PoolSize);

  bfra_pkg::state_e state_q, state_d;

  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             rd_vld_q, rd_vld_d;
  logic [IdxW-1:0]  rd_idx_q, rd_idx_d;
  logic [NRuns-1:0] valid_q, valid_d;
  logic [LenW-1:0]  top_q, top_d;
  logic             out_valid_q, out_valid_d;

  logic             best_found_q, best_found_d;
  logic             prev_found_q, prev_found_d;
  logic             next_found_q, next_found_d;
  logic             next_done_q, next_done_d;
  logic             empty_found_q, empty_found_d;

  bfra_pkg::in_t    req_q, req_d;
  logic [IdxW-1:0]  best_idx_q, best_idx_d;
  logic [LenW-1:0]  best_len_q, best_len_d;
  logic [SlotW-1:0] best_start_q, best_start_d;
  logic [IdxW-1:0]  prev_idx_q, prev_idx_d;
  logic [SlotW-1:0] prev_start_q, prev_start_d;
  logic [IdxW-1:0]  next_idx_q, next_idx_d;
  logic [IdxW-1:0]  empty_idx_q, empty_idx_d;
  logic [LenW-1:0]  acc_len_q, acc_len_d;
  bfra_pkg::out_t   pend_q, pend_d;
  bfra_pkg::out_t   out_q, out_d;

  bfra_pkg::wr_t    wr;
  logic [SlotW-1:0] rd_start;
  logic [LenW-1:0]  rd_len;

  logic             issue;
  logic             ent_vld;
  logic [LenW-1:0]  req_len;
  logic [LenW-1:0]  req_end;
  logic [LenW:0]    ent_end;
  logic             fits, better, prev_hit, next_hit;
  logic [LenW-1:0]  in_end;
  logic [LenW-1:0]  top_end;
  logic [LenW-1:0]  rest;

  bfra_run_table u_table (
    .clk_i      (clk_i),
    .wr_i       (wr),
    .rd_addr_i  (cnt_q[IdxW-1:0]),
    .rd_start_o (rd_start),
    .rd_len_o   (rd_len)
  );

  assign in_stall_o  = (state_q != bfra_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign issue   = (state_q == bfra_pkg::ST_SCAN) && (cnt_q != CntW'(NRuns));
  assign ent_vld = valid_q[rd_idx_q];
  assign req_len = {1'b0, req_q.run_length};
  assign req_end = {1'b0, req_q.start_index} + req_len;
  assign ent_end = {2'b00, rd_start} + {1'b0, rd_len};
  assign in_end  = {1'b0, in_data_i.start_index} + {1'b0, in_data_i.run_length};
  assign top_end = top_q + req_len;
  assign rest    = best_len_q - req_len;

  assign fits   = ent_vld && (rd_len >= req_len);
  assign better = !best_found_q || (rd_len < best_len_q) ||
                  ((rd_len == best_len_q) && (rd_start < best_start_q));
  assign prev_hit = ent_vld && !prev_found_q &&
                    (ent_end == {2'b00, req_q.start_index});
  assign next_hit = ent_vld && !next_done_q && ({1'b0, rd_start} == req_end);

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    rd_vld_d      = 1'b0;
    rd_idx_d      = rd_idx_q;
    valid_d       = valid_q;
    top_d         = top_q;
    out_valid_d   = out_valid_q;
    best_found_d  = best_found_q;
    prev_found_d  = prev_found_q;
    next_found_d  = next_found_q;
    next_done_d   = next_done_q;
    empty_found_d = empty_found_q;
    req_d         = req_q;
    best_idx_d    = best_idx_q;
    best_len_d    = best_len_q;
    best_start_d  = best_start_q;
    prev_idx_d    = prev_idx_q;
    prev_start_d  = prev_start_q;
    next_idx_d    = next_idx_q;
    empty_idx_d   = empty_idx_q;
    acc_len_d     = acc_len_q;
    pend_d        = pend_q;
    out_d         = out_q;
    wr            = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      bfra_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          req_d         = in_data_i;
          cnt_d         = '0;
          best_found_d  = 1'b0;
          prev_found_d  = 1'b0;
          next_found_d  = 1'b0;
          next_done_d   = 1'b0;
          empty_found_d = 1'b0;
          acc_len_d     = {1'b0, in_data_i.run_length};
          pend_d        = '0;
          state_d       = bfra_pkg::ST_SCAN;
          // requests settled without the table
          if (in_data_i.opcode == bfra_pkg::OpAlloc) begin
            if (in_data_i.run_length == '0) begin
              pend_d.status = bfra_pkg::StNoSpace;
              state_d       = bfra_pkg::ST_DONE;
            end
          end else if (in_data_i.run_length == '0) begin
            pend_d.status = bfra_pkg::StOkRun;
            state_d       = bfra_pkg::ST_DONE;
          end else if (in_end > PoolLimit) begin
            pend_d.status = bfra_pkg::StNoSpace;
            state_d       = bfra_pkg::ST_DONE;
          end
        end
      end

      bfra_pkg::ST_SCAN: begin
        rd_vld_d = issue;
        if (issue) begin
          rd_idx_d = cnt_q[IdxW-1:0];
          cnt_d    = cnt_q + CntW'(1);
        end
        if (rd_vld_q) begin
          if (req_q.opcode == bfra_pkg::OpAlloc) begin
            if (fits && better) begin
              best_found_d = 1'b1;
              best_idx_d   = rd_idx_q;
              best_len_d   = rd_len;
              best_start_d = rd_start;
            end
          end else begin
            if (!ent_vld && !empty_found_q) begin
              empty_found_d = 1'b1;
              empty_idx_d   = rd_idx_q;
            end
            if (prev_hit || next_hit) begin
              // merged entries leave the table as they are found
              acc_len_d          = acc_len_q + rd_len;
              valid_d[rd_idx_q]  = 1'b0;
            end
            if (prev_hit) begin
              prev_found_d = 1'b1;
              prev_idx_d   = rd_idx_q;
              prev_start_d = rd_start;
            end
            if (next_hit) begin
              // an entry that is both neighbors counts once, as the lower one
              next_done_d = 1'b1;
              if (!prev_hit) begin
                next_found_d = 1'b1;
                next_idx_d   = rd_idx_q;
              end
            end
          end
          if (!issue) begin
            state_d = bfra_pkg::ST_WRITE;
          end
        end
      end

      bfra_pkg::ST_WRITE: begin
        state_d = bfra_pkg::ST_DONE;
        pend_d  = '0;
        if (req_q.opcode == bfra_pkg::OpAlloc) begin
          if (best_found_q) begin
            pend_d.slot_index = best_start_q + rest[SlotW-1:0];
            pend_d.status     = bfra_pkg::StOkRun;
            if (rest != '0) begin
              wr.en   = 1'b1;
              wr.addr = best_idx_q;
              wr.len  = rest;
            end else begin
              valid_d[best_idx_q] = 1'b0;
            end
          end else if (top_end > PoolLimit) begin
            pend_d.status = bfra_pkg::StNoSpace;
          end else begin
            pend_d.slot_index = top_q[SlotW-1:0];
            pend_d.status     = bfra_pkg::StOkTop;
            top_d             = top_end;
          end
        end else if (prev_found_q || next_found_q || empty_found_q) begin
          wr.en       = 1'b1;
          wr.start_en = 1'b1;
          wr.len      = acc_len_q;
          wr.start    = prev_found_q ? prev_start_q : req_q.start_index;
          wr.addr     = prev_found_q ? prev_idx_q :
                        (next_found_q ? next_idx_q : empty_idx_q);
          valid_d[wr.addr] = 1'b1;
          pend_d.status    = bfra_pkg::StOkRun;
        end else begin
          pend_d.status = bfra_pkg::StTableFull;
        end
      end

      bfra_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = pend_q;
          out_valid_d = 1'b1;
          state_d     = bfra_pkg::ST_IDLE;
        end
      end

      default: state_d = bfra_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= bfra_pkg::ST_IDLE;
      cnt_q         <= '0;
      rd_vld_q      <= 1'b0;
      valid_q       <= '0;
      top_q         <= '0;
      out_valid_q   <= 1'b0;
      best_found_q  <= 1'b0;
      prev_found_q  <= 1'b0;
      next_found_q  <= 1'b0;
      next_done_q   <= 1'b0;
      empty_found_q <= 1'b0;
    end else begin
      state_q       <= state_d;
      cnt_q         <= cnt_d;
      rd_vld_q      <= rd_vld_d;
      valid_q       <= valid_d;
      top_q         <= top_d;
      out_valid_q   <= out_valid_d;
      best_found_q  <= best_found_d;
      prev_found_q  <= prev_found_d;
      next_found_q  <= next_found_d;
      next_done_q   <= next_done_d;
      empty_found_q <= empty_found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q     <= rd_idx_d;
    req_q        <= req_d;
    best_idx_q   <= best_idx_d;
    best_len_q   <= best_len_d;
    best_start_q <= best_start_d;
    prev_idx_q   <= prev_idx_d;
    prev_start_q <= prev_start_d;
    next_idx_q   <= next_idx_d;
    empty_idx_q  <= empty_idx_d;
    acc_len_q    <= acc_len_d;
    pend_q       <= pend_d;
    out_q        <= out_d;
  end

`ifndef SYNTHESIS
  a_top_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    top_q <= PoolLimit)
    else $error("top pointer beyond pool");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == bfra_pkg::ST_DONE))
    else $error("result appeared outside done state");

  a_read_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (state_q == bfra_pkg::ST_SCAN))
    else $error("table read data outside scan");

  a_busy_after_transfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request taken while previous one in flight");
`endif

endmodule
